// ----- rtl/core/matinv_pkg.sv -----
// ----------------------------------------------------------------------------
// matinv_pkg
// Widths and types shared by the 3x3 adjugate matrix inverse.
// ----------------------------------------------------------------------------
package matinv_pkg;

  localparam int EW        = 32;
  localparam int FB        = 16;
  localparam int DIM       = 3;
  localparam int NEL       = DIM * DIM;
  localparam int PW        = 2 * EW;
  localparam int CW        = PW + 1;
  localparam int HW        = CW - EW;
  localparam int PPW       = EW + HW;
  localparam int DW        = EW + CW + 2;
  localparam int NW        = CW + 2 * FB;
  localparam int RW        = DW + EW;
  localparam int DIV_STEPS = EW;
  localparam int FRONT     = 5;
  localparam int NSTG      = FRONT + DIV_STEPS + 1;

  typedef logic signed [EW-1:0] elem_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [CW-1:0] cof_t;
  typedef logic signed [PPW-1:0] pp_t;
  typedef logic signed [DW-1:0] det_t;
  typedef logic [RW-1:0] rem_t;
  typedef logic [EW-1:0] quo_t;

endpackage

// ----- rtl/core/matrix_inverse_3x3_top.sv -----
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_top
// Pipelined 3x3 matrix inverse by the adjugate, signed Q16.16 in and out.
//
// The input channel (in_valid/in_ready) carries one matrix per transaction and
// the result channel (out_valid/out_ready) one inverse with singular and
// overflow flags. One matrix can be accepted in every cycle in which the
// pipeline advances; each passes through 39 register stages. Five stages
// form the cofactors and the exact determinant, one stage checks for a
// quotient above the element range, and a chain of 32 restoring division
// stages, one quotient bit each with nine lanes sharing one divisor,
// produces the entries. A last stage saturates and registers the result.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so a receiver stall holds every stage and in_ready drops;
// nothing is lost or repeated. Reset clears all valid bits; data registers
// are not reset.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [matinv_pkg::EW-1:0] in_a00,
  input  logic signed [matinv_pkg::EW-1:0] in_a01,
  input  logic signed [matinv_pkg::EW-1:0] in_a02,
  input  logic signed [matinv_pkg::EW-1:0] in_a10,
  input  logic signed [matinv_pkg::EW-1:0] in_a11,
  input  logic signed [matinv_pkg::EW-1:0] in_a12,
  input  logic signed [matinv_pkg::EW-1:0] in_a20,
  input  logic signed [matinv_pkg::EW-1:0] in_a21,
  input  logic signed [matinv_pkg::EW-1:0] in_a22,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [matinv_pkg::EW-1:0] out_inv00,
  output logic signed [matinv_pkg::EW-1:0] out_inv01,
  output logic signed [matinv_pkg::EW-1:0] out_inv02,
  output logic signed [matinv_pkg::EW-1:0] out_inv10,
  output logic signed [matinv_pkg::EW-1:0] out_inv11,
  output logic signed [matinv_pkg::EW-1:0] out_inv12,
  output logic signed [matinv_pkg::EW-1:0] out_inv20,
  output logic signed [matinv_pkg::EW-1:0] out_inv21,
  output logic signed [matinv_pkg::EW-1:0] out_inv22,
  output logic                          out_singular,
  output logic                          out_overflow
);
  import matinv_pkg::*;

  localparam quo_t QMAX = {1'b0, {(EW-1){1'b1}}};
  localparam quo_t QMIN = {1'b1, {(EW-1){1'b0}}};

  logic adv;
  logic [NSTG-1:0] vld_r;
  logic out_valid_r;

  elem_t a [NEL];

  prod_t p1_r [NEL];
  prod_t p2_r [NEL];
  elem_t r0a_r [DIM];
  cof_t  cof2_r [NEL];
  elem_t r0b_r [DIM];
  pp_t   pl_r [DIM];
  pp_t   ph_r [DIM];
  cof_t  cof3_r [NEL];
  det_t  det_r;
  cof_t  cof4_r [NEL];
  logic [DW-1:0] den5_r;
  logic [NW-1:0] num5_r [NEL];
  logic          neg5_r [NEL];
  logic          sng5_r;

  rem_t dden_r [DIV_STEPS+1];
  rem_t drem_r [DIV_STEPS+1][NEL];
  quo_t dq_r   [DIV_STEPS+1][NEL];
  logic dneg_r [DIV_STEPS+1][NEL];
  logic dsat_r [DIV_STEPS+1][NEL];
  logic dsng_r [DIV_STEPS+1];

  elem_t inv_r [NEL];
  logic  sng_r;
  logic  ovf_r;

  assign a[0] = in_a00;
  assign a[1] = in_a01;
  assign a[2] = in_a02;
  assign a[3] = in_a10;
  assign a[4] = in_a11;
  assign a[5] = in_a12;
  assign a[6] = in_a20;
  assign a[7] = in_a21;
  assign a[8] = in_a22;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NSTG-2:0], in_valid};
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  // Cofactor products and differences.
  for (genvar i = 0; i < DIM; i++) begin : g_row
    for (genvar j = 0; j < DIM; j++) begin : g_col
      localparam int R1 = (j + 1) % DIM;
      localparam int R2 = (j + 2) % DIM;
      localparam int C1 = (i + 1) % DIM;
      localparam int C2 = (i + 2) % DIM;
      localparam int K  = i * DIM + j;
      always_ff @(posedge clk) begin
        if (adv) begin
          p1_r[K]   <= a[R1*DIM+C1] * a[R2*DIM+C2];
          p2_r[K]   <= a[R1*DIM+C2] * a[R2*DIM+C1];
          cof2_r[K] <= CW'(p1_r[K]) - CW'(p2_r[K]);
          cof3_r[K] <= cof2_r[K];
          cof4_r[K] <= cof3_r[K];
        end
      end
    end
  end

  // Determinant along the first row, each 32x65 product split into two halves.
  for (genvar i = 0; i < DIM; i++) begin : g_det
    always_ff @(posedge clk) begin
      if (adv) begin
        r0a_r[i] <= a[i];
        r0b_r[i] <= r0a_r[i];
        pl_r[i]  <= PPW'(r0b_r[i]) * PPW'($signed({1'b0, cof2_r[i*DIM][EW-1:0]}));
        ph_r[i]  <= PPW'(r0b_r[i]) * PPW'($signed(cof2_r[i*DIM][CW-1:EW]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      det_r <= (DW'(ph_r[0]) <<< EW) + DW'(pl_r[0])
             + (DW'(ph_r[1]) <<< EW) + DW'(pl_r[1])
             + (DW'(ph_r[2]) <<< EW) + DW'(pl_r[2]);
      den5_r <= det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
      sng5_r <= (det_r == '0);
      dden_r[0] <= RW'(den5_r);
      dsng_r[0] <= sng5_r;
    end
  end

  for (genvar k = 0; k < NEL; k++) begin : g_num
    always_ff @(posedge clk) begin
      if (adv) begin
        num5_r[k] <= (cof4_r[k][CW-1] ? NW'(-cof4_r[k]) : NW'(cof4_r[k])) << (2 * FB);
        neg5_r[k] <= cof4_r[k][CW-1] ^ det_r[DW-1];
        drem_r[0][k] <= RW'(num5_r[k]);
        dq_r[0][k]   <= '0;
        dneg_r[0][k] <= neg5_r[k];
        dsat_r[0][k] <= RW'(num5_r[k]) >= (RW'(den5_r) << EW);
      end
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    localparam int B = DIV_STEPS - 1 - s;
    always_ff @(posedge clk) begin
      if (adv) begin
        dden_r[s+1] <= dden_r[s];
        dsng_r[s+1] <= dsng_r[s];
      end
    end
    for (genvar k = 0; k < NEL; k++) begin : g_lane
      logic [RW:0] trial;
      assign trial = {1'b0, drem_r[s][k]} - {1'b0, dden_r[s] << B};
      always_ff @(posedge clk) begin
        if (adv) begin
          drem_r[s+1][k] <= trial[RW] ? drem_r[s][k] : trial[RW-1:0];
          dq_r[s+1][k]   <= {dq_r[s][k][EW-2:0], !trial[RW]};
          dneg_r[s+1][k] <= dneg_r[s][k];
          dsat_r[s+1][k] <= dsat_r[s][k];
        end
      end
    end
  end

  // Sign, saturation and singular handling.
  logic [NEL-1:0] lane_ovf;
  elem_t          lane_val [NEL];

  for (genvar k = 0; k < NEL; k++) begin : g_out
    quo_t q;
    logic n;
    assign q = dq_r[DIV_STEPS][k];
    assign n = dneg_r[DIV_STEPS][k];
    assign lane_ovf[k] = dsat_r[DIV_STEPS][k] || (!n && q[EW-1])
                       || (n && q[EW-1] && (|q[EW-2:0]));
    assign lane_val[k] = lane_ovf[k] ? (n ? QMIN : QMAX) : (n ? EW'(-q) : q);
    always_ff @(posedge clk) begin
      if (adv) begin
        inv_r[k] <= dsng_r[DIV_STEPS] ? '0 : lane_val[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sng_r <= dsng_r[DIV_STEPS];
      ovf_r <= !dsng_r[DIV_STEPS] && (|lane_ovf);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_inv00    = inv_r[0];
  assign out_inv01    = inv_r[1];
  assign out_inv02    = inv_r[2];
  assign out_inv10    = inv_r[3];
  assign out_inv11    = inv_r[4];
  assign out_inv12    = inv_r[5];
  assign out_inv20    = inv_r[6];
  assign out_inv21    = inv_r[7];
  assign out_inv22    = inv_r[8];
  assign out_singular = sng_r;
  assign out_overflow = ovf_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled while output register empty");

  a_singular_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_singular) |-> (!out_overflow && out_inv00 == '0 && out_inv22 == '0))
    else $error("singular result carries nonzero data or overflow");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule
